// ===== sv/fwcrc_pkg.sv =====
package fwcrc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned S_TDATA_W = 4 * WORD_W + BYTE_W;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned VERDICT_W = 2;
    localparam int unsigned M_PAD_W   = M_TDATA_W - WORD_W - VERDICT_W;

    typedef enum logic [0:0] {
        ACT_HEADER = 1'b0,
        ACT_DATA   = 1'b1
    } action_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_VALID        = 2'd0,
        VERDICT_BAD_MAGIC    = 2'd1,
        VERDICT_BAD_SIZE     = 2'd2,
        VERDICT_CRC_MISMATCH = 2'd3
    } verdict_t;

    localparam logic [WORD_W-1:0] NIB_TABLE [16] = '{
        32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
        32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
        32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
        32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
    };

    // reflected crc-32, low nibble first, inverted on entry and exit
    function automatic logic [WORD_W-1:0] crc_byte(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [WORD_W-1:0] c;
        logic [NIB_W-1:0]  idx;
        c   = ~crc;
        idx = c[NIB_W-1:0] ^ data[NIB_W-1:0];
        c   = (c >> NIB_W) ^ NIB_TABLE[idx];
        idx = c[NIB_W-1:0] ^ data[BYTE_W-1:NIB_W];
        c   = (c >> NIB_W) ^ NIB_TABLE[idx];
        return ~c;
    endfunction

endpackage

// ===== sv/firmware_image_crc_verifier_core.sv =====
// Firmware image checker. Send one header beat (tuser action 0) carrying the magic word,
// stored size, full size and expected CRC, then full_size data beats (action 1), one image
// byte each. A header with a magic word other than expected_magic, or with stored size above
// full size, gets a failure verdict at once with computed_crc 0; an empty image gets its
// verdict at once as well. Otherwise the block runs the reflected CRC-32 (poly 0xEDB88320,
// init 0, inverted in and out) over the bytes and returns one verdict beat after the last
// byte. Data beats outside a run are dropped, and a new header abandons a run without a
// result. One beat is accepted every cycle unless the output stalls; a result passes the
// input register, then one byte-wide CRC update into the result register. expected_magic is
// written via cfg_wr_en/cfg_wr_data, by the user only while the block is idle; not enforced.
module firmware_image_crc_verifier_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [fwcrc_pkg::WORD_W-1:0]       cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // header_magic, stored_size, full_size, expected_crc, data_byte
    input  logic [fwcrc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // action
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // verdict, computed_crc, zero pad
    output logic [fwcrc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned W = fwcrc_pkg::WORD_W;

    logic [W-1:0]                     magic_reg;

    logic                             in_valid_reg, in_valid_next;
    fwcrc_pkg::action_t               in_action_reg;
    logic [fwcrc_pkg::S_TDATA_W-1:0]  in_data_reg;

    logic [W-1:0]                     running_crc_reg, running_crc_next;
    logic [W-1:0]                     bytes_left_reg, bytes_left_next;
    logic [W-1:0]                     target_crc_reg, target_crc_next;
    logic                             check_active_reg, check_active_next;

    logic                             out_valid_reg, out_valid_next;
    fwcrc_pkg::verdict_t              out_verdict_reg, out_verdict_next;
    logic [W-1:0]                     out_crc_reg, out_crc_next;

    logic                             advance;
    logic                             emit;
    fwcrc_pkg::verdict_t              verdict;
    logic [W-1:0]                     result_crc;
    logic [W-1:0]                     crc_new;

    logic [W-1:0]                     hdr_magic;
    logic [W-1:0]                     hdr_ssize;
    logic [W-1:0]                     hdr_fsize;
    logic [W-1:0]                     hdr_ecrc;
    logic [fwcrc_pkg::BYTE_W-1:0]     data_byte;

    assign hdr_magic = in_data_reg[W-1:0];
    assign hdr_ssize = in_data_reg[2*W-1:W];
    assign hdr_fsize = in_data_reg[3*W-1:2*W];
    assign hdr_ecrc  = in_data_reg[4*W-1:3*W];
    assign data_byte = in_data_reg[4*W+fwcrc_pkg::BYTE_W-1:4*W];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    assign crc_new = fwcrc_pkg::crc_byte(running_crc_reg, data_byte);

    always_comb
    begin
        running_crc_next  = running_crc_reg;
        bytes_left_next   = bytes_left_reg;
        target_crc_next   = target_crc_reg;
        check_active_next = check_active_reg;
        emit              = 1'b0;
        verdict           = fwcrc_pkg::VERDICT_VALID;
        result_crc        = '0;
        if (in_valid_reg && advance)
        begin
            if (in_action_reg == fwcrc_pkg::ACT_HEADER)
            begin
                running_crc_next  = '0;
                bytes_left_next   = '0;
                target_crc_next   = '0;
                check_active_next = 1'b0;
                priority if (hdr_magic != magic_reg)
                begin
                    emit    = 1'b1;
                    verdict = fwcrc_pkg::VERDICT_BAD_MAGIC;
                end
                else if (hdr_ssize > hdr_fsize)
                begin
                    emit    = 1'b1;
                    verdict = fwcrc_pkg::VERDICT_BAD_SIZE;
                end
                else if (hdr_fsize == '0)
                begin
                    target_crc_next = hdr_ecrc;
                    emit            = 1'b1;
                    verdict         = (hdr_ecrc == '0) ? fwcrc_pkg::VERDICT_VALID
                                                       : fwcrc_pkg::VERDICT_CRC_MISMATCH;
                end
                else
                begin
                    target_crc_next   = hdr_ecrc;
                    bytes_left_next   = hdr_fsize;
                    check_active_next = 1'b1;
                end
            end
            else if (check_active_reg)
            begin
                running_crc_next = crc_new;
                bytes_left_next  = bytes_left_reg - W'(1);
                if (bytes_left_reg == W'(1))
                begin
                    check_active_next = 1'b0;
                    emit              = 1'b1;
                    result_crc        = crc_new;
                    verdict           = (crc_new == target_crc_reg)
                                        ? fwcrc_pkg::VERDICT_VALID
                                        : fwcrc_pkg::VERDICT_CRC_MISMATCH;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_verdict_next = out_verdict_reg;
        out_crc_next     = out_crc_reg;
        if (advance)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_verdict_next = verdict;
                out_crc_next     = result_crc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg        <= '0;
            in_valid_reg     <= 1'b0;
            running_crc_reg  <= '0;
            bytes_left_reg   <= '0;
            target_crc_reg   <= '0;
            check_active_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                magic_reg <= cfg_wr_data;
            end
            in_valid_reg     <= in_valid_next;
            running_crc_reg  <= running_crc_next;
            bytes_left_reg   <= bytes_left_next;
            target_crc_reg   <= target_crc_next;
            check_active_reg <= check_active_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= fwcrc_pkg::action_t'(s_axis_tuser);
            in_data_reg   <= s_axis_tdata;
        end
        out_verdict_reg <= out_verdict_next;
        out_crc_reg     <= out_crc_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{fwcrc_pkg::M_PAD_W{1'b0}}, out_crc_reg, out_verdict_reg};

    a_idle_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !check_active_reg |-> bytes_left_reg == '0)
        else $error("bytes pending with no active run");

    a_active_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        check_active_reg |-> bytes_left_reg != '0)
        else $error("active run with zero bytes left");

    a_early_fail_zero_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_verdict_reg == fwcrc_pkg::VERDICT_BAD_MAGIC ||
                           out_verdict_reg == fwcrc_pkg::VERDICT_BAD_SIZE))
        |-> out_crc_reg == '0)
        else $error("early failure carries nonzero crc");

    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a processed beat");

endmodule
